>>> rtl/ffha_pkg.sv
// shared types and constants for the first-fit heap allocator
`default_nettype none

package ffha_pkg;

    // default arena size in bytes
    localparam int ARENA_BYTES_DEF = 32768;

    // field widths
    localparam int SIZE_W = 15;
    localparam int ADDR_W = 15;
    localparam int HDR_W  = 16;
    localparam int CNT_W  = 14;
    localparam int OFF_W  = 17;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // result codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOSPACE = 3'd1,
        ST_BADADDR = 3'd2,
        ST_ISFREE  = 3'd3,
        ST_NONE    = 3'd4
    } status_t;

    // request codes
    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

    // walk sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_SPLIT,
        S_DONE
    } state_t;

    // header store port strobes
    typedef struct packed {
        logic we;
        logic re;
    } ram_ctl_t;

endpackage

`default_nettype wire

>>> rtl/ffha_if.sv
// request and response channel interfaces
`default_nettype none

interface ffha_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [ffha_pkg::SIZE_W-1:0]  alloc_size;
    logic [ffha_pkg::ADDR_W-1:0]  free_addr;

    modport source (output valid, output req_type, output alloc_size, output free_addr,
                    input ready);
    modport sink (input valid, input req_type, input alloc_size, input free_addr,
                  output ready);
endinterface

interface ffha_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   status;
    logic [ffha_pkg::ADDR_W-1:0]  payload_addr;
    logic [ffha_pkg::CNT_W-1:0]   live_blocks;

    modport source (output valid, output status, output payload_addr, output live_blocks,
                    input ready);
    modport sink (input valid, input status, input payload_addr, input live_blocks,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/ffha_hdr_ram.sv
// header store: synchronous ram with a registered read and a reset-time view of word zero
`default_nettype none

module ffha_hdr_ram #(
    parameter int                          DEPTH    = ffha_pkg::ARENA_BYTES_DEF / 2,
    parameter int                          IDX_W    = $clog2(ffha_pkg::ARENA_BYTES_DEF / 2),
    parameter logic [ffha_pkg::HDR_W-1:0]  INIT_HDR = ffha_pkg::HDR_W'(ffha_pkg::ARENA_BYTES_DEF)
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire  ffha_pkg::ram_ctl_t     ctl,
    input  wire  [IDX_W-1:0]             widx,
    input  wire  [ffha_pkg::HDR_W-1:0]   wdata,
    input  wire  [IDX_W-1:0]             ridx,
    output logic [ffha_pkg::HDR_W-1:0]   rdata
);

    logic [ffha_pkg::HDR_W-1:0] mem [DEPTH];
    logic [ffha_pkg::HDR_W-1:0] q_reg;
    logic                       w0_reg;
    logic                       rzero_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[widx] <= wdata;
        end
        if (ctl.re)
        begin
            q_reg <= mem[ridx];
        end
    end

    // word zero reads as the whole-arena header until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w0_reg    <= 1'b0;
            rzero_reg <= 1'b0;
        end
        else
        begin
            if (ctl.we && widx == '0)
            begin
                w0_reg <= 1'b1;
            end
            if (ctl.re)
            begin
                rzero_reg <= (ridx == '0);
            end
        end
    end

    assign rdata = (rzero_reg && !w0_reg) ? INIT_HDR : q_reg;

endmodule

`default_nettype wire

>>> rtl/first_fit_heap_allocator.sv
// first-fit heap allocator over an implicit free list of block headers
//
//  channel | dir | words                                   | accepted when
//  req     | in  | req_type, alloc_size, free_addr         | req.valid && req.ready
//  rsp     | out | status, payload_addr, live_blocks       | rsp.valid && rsp.ready
//
// sequence: take the request, then a ram read and an evaluate step per header walked,
//   a remainder header write for a split, and a hand-off of the result.
//   the walk length is set by the block chain, one header per ram access.
// reset: the ram is not cleared; word zero reads as one free block of the whole
//   arena until first written. live count and control reset to zero.
// stalls: a result waits in the output register while the next request is
//   taken; the sequencer holds in its hand-off state only if that register is full.
`default_nettype none

module first_fit_heap_allocator #(
    parameter int ARENA_BYTES = ffha_pkg::ARENA_BYTES_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    ffha_req_if.sink    req,
    ffha_rsp_if.source  rsp
);

    localparam int ARENA_END = ARENA_BYTES - (ARENA_BYTES % 2);
    localparam int DEPTH     = ARENA_END / 2;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int OFF_W     = ffha_pkg::OFF_W;

    localparam logic [OFF_W-1:0]            END_OFF  = OFF_W'(ARENA_END);
    localparam logic [ffha_pkg::HDR_W-1:0]  INIT_HDR = ffha_pkg::HDR_W'(ARENA_END);

    // sequencer and item state
    ffha_pkg::state_t                state_reg, state_next;
    ffha_pkg::req_t                  type_reg, type_next;
    logic [OFF_W-1:0]                need_reg, need_next;   // block bytes incl. header
    logic [OFF_W-1:0]                tgt_reg, tgt_next;     // header offset to free
    logic [OFF_W-1:0]                off_reg, off_next;     // walk position
    logic [ffha_pkg::HDR_W-1:0]      val_reg, val_next;     // remainder header
    ffha_pkg::status_t               st_reg, st_next;
    logic [ffha_pkg::ADDR_W-1:0]     addr_reg, addr_next;
    logic [ffha_pkg::CNT_W-1:0]      live_reg, live_next;

    // output register
    logic                            out_valid_reg, out_valid_next;
    ffha_pkg::status_t               out_st_reg, out_st_next;
    logic [ffha_pkg::ADDR_W-1:0]     out_addr_reg, out_addr_next;
    logic [ffha_pkg::CNT_W-1:0]      out_live_reg, out_live_next;

    // header store port
    ffha_pkg::ram_ctl_t              ram_ctl;
    logic [IDX_W-1:0]                ram_widx;
    logic [IDX_W-1:0]                ram_ridx;
    logic [ffha_pkg::HDR_W-1:0]      ram_wdata;
    logic [ffha_pkg::HDR_W-1:0]      hdr;

    // header decode
    logic [OFF_W-1:0]                sz;
    logic                            used;
    logic [OFF_W-1:0]                nxt;
    logic [OFF_W-1:0]                pa_ext;

    ffha_hdr_ram #(
        .DEPTH    (DEPTH),
        .IDX_W    (IDX_W),
        .INIT_HDR (INIT_HDR)
    ) u_hdr_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ram_ctl),
        .widx  (ram_widx),
        .wdata (ram_wdata),
        .ridx  (ram_ridx),
        .rdata (hdr)
    );

    assign sz     = {1'b0, hdr & ~ffha_pkg::HDR_W'(1)};
    assign used   = hdr[0];
    assign nxt    = off_reg + sz;
    assign pa_ext = {{(OFF_W - ffha_pkg::ADDR_W){1'b0}}, req.free_addr};

    assign req.ready        = (state_reg == ffha_pkg::S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_st_reg;
    assign rsp.payload_addr = out_addr_reg;
    assign rsp.live_blocks  = out_live_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffha_pkg::S_IDLE;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg     <= type_next;
        need_reg     <= need_next;
        tgt_reg      <= tgt_next;
        off_reg      <= off_next;
        val_reg      <= val_next;
        st_reg       <= st_next;
        addr_reg     <= addr_next;
        out_st_reg   <= out_st_next;
        out_addr_reg <= out_addr_next;
        out_live_reg <= out_live_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        type_next      = type_reg;
        need_next      = need_reg;
        tgt_next       = tgt_reg;
        off_next       = off_reg;
        val_next       = val_reg;
        st_next        = st_reg;
        addr_next      = addr_reg;
        live_next      = live_reg;
        out_valid_next = out_valid_reg;
        out_st_next    = out_st_reg;
        out_addr_next  = out_addr_reg;
        out_live_next  = out_live_reg;
        ram_ctl        = '0;
        ram_widx       = off_reg[IDX_W:1];
        ram_ridx       = off_reg[IDX_W:1];
        ram_wdata      = val_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ffha_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    type_next = ffha_pkg::req_t'(req.req_type);
                    // round up to even, plus two header bytes
                    need_next = ((OFF_W'(req.alloc_size) + OFF_W'(1)) & ~OFF_W'(1))
                                + OFF_W'(2);
                    tgt_next  = pa_ext - OFF_W'(2);
                    off_next  = '0;
                    addr_next = '0;
                    st_next   = ffha_pkg::ST_OK;
                    state_next = ffha_pkg::S_READ;
                    if (req.req_type == ffha_pkg::REQ_ALLOC)
                    begin
                        if (live_reg == ffha_pkg::COUNT_MAX)
                        begin
                            st_next    = ffha_pkg::ST_NOSPACE;
                            state_next = ffha_pkg::S_DONE;
                        end
                    end
                    else if (live_reg == '0)
                    begin
                        st_next    = ffha_pkg::ST_NONE;
                        state_next = ffha_pkg::S_DONE;
                    end
                    else if (req.free_addr[0] || pa_ext < OFF_W'(2)
                             || (pa_ext - OFF_W'(2)) >= END_OFF)
                    begin
                        st_next    = ffha_pkg::ST_BADADDR;
                        state_next = ffha_pkg::S_DONE;
                    end
                end
            end

            ffha_pkg::S_READ:
            begin
                ram_ctl.re = 1'b1;
                state_next = ffha_pkg::S_EVAL;
            end

            ffha_pkg::S_EVAL:
            begin
                state_next = ffha_pkg::S_DONE;
                if (type_reg == ffha_pkg::REQ_ALLOC)
                begin
                    if (sz == '0)
                    begin
                        // zero-size header ends the chain
                        st_next = ffha_pkg::ST_NOSPACE;
                    end
                    else if (!used && sz >= need_reg)
                    begin
                        ram_ctl.we = 1'b1;
                        live_next  = live_reg + ffha_pkg::CNT_W'(1);
                        addr_next  = off_reg[ffha_pkg::ADDR_W-1:0] + ffha_pkg::ADDR_W'(2);
                        if (sz <= need_reg + OFF_W'(2))
                        begin
                            // take the block whole
                            ram_wdata = sz[ffha_pkg::HDR_W-1:0] | ffha_pkg::HDR_W'(1);
                        end
                        else
                        begin
                            // split: remainder header written next cycle
                            ram_wdata  = need_reg[ffha_pkg::HDR_W-1:0] | ffha_pkg::HDR_W'(1);
                            off_next   = off_reg + need_reg;
                            val_next   = ffha_pkg::HDR_W'(sz - need_reg);
                            state_next = ffha_pkg::S_SPLIT;
                        end
                    end
                    else
                    begin
                        // too small or in use: step to the next header
                        off_next = nxt;
                        if (nxt >= END_OFF)
                        begin
                            st_next = ffha_pkg::ST_NOSPACE;
                        end
                        else
                        begin
                            state_next = ffha_pkg::S_READ;
                        end
                    end
                end
                else
                begin
                    if (off_reg == tgt_reg)
                    begin
                        if (!used)
                        begin
                            st_next = ffha_pkg::ST_ISFREE;
                        end
                        else
                        begin
                            ram_ctl.we = 1'b1;
                            ram_wdata  = sz[ffha_pkg::HDR_W-1:0];
                            live_next  = live_reg - ffha_pkg::CNT_W'(1);
                        end
                    end
                    else if (sz == '0 || nxt > tgt_reg)
                    begin
                        // address is not on the chain
                        st_next = ffha_pkg::ST_BADADDR;
                    end
                    else
                    begin
                        off_next   = nxt;
                        state_next = ffha_pkg::S_READ;
                    end
                end
            end

            ffha_pkg::S_SPLIT:
            begin
                ram_ctl.we = 1'b1;
                state_next = ffha_pkg::S_DONE;
            end

            ffha_pkg::S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = st_reg;
                    out_addr_next  = (st_reg == ffha_pkg::ST_OK) ? addr_reg : '0;
                    out_live_next  = live_reg;
                    state_next     = ffha_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ffha_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// self-checking testbench for the first-fit heap allocator
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ffha_pkg::*;

    // usable arena: size rounded down to even, capped at what the header store covers
    localparam int ARENA_END = ((ARENA_BYTES_DEF & 'hFFFE) > 32768) ? 32768
                                                                      : (ARENA_BYTES_DEF & 'hFFFE);
    localparam int HDR_WORDS    = 16384;
    localparam int IDLE_PCT     = 24;
    localparam int RANDOM_WORDS = 1000;
    localparam int SIZE_TOP     = 32766;
    localparam int ADDR_TOP     = 32767;

    // one expected response word
    typedef struct packed {
        status_t            status;
        logic [ADDR_W-1:0]  addr;
        logic [CNT_W-1:0]   live;
    } heap_outcome_t;

    logic clk = 1'b0;
    logic rst_n;
    bit   quiet;        // both sides run flat out while set
    int   mismatches;

    ffha_req_if req();
    ffha_rsp_if rsp();

    first_fit_heap_allocator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // predictor state: block headers indexed by byte offset / 2, and the live count
    logic [HDR_W-1:0]  hdr_words [HDR_WORDS];
    int                live_now;

    // expected response words, oldest first
    heap_outcome_t     outcomes_q [$];

    // payload addresses handed out: those still live, and every one ever granted
    logic [ADDR_W-1:0] live_addrs [$];
    logic [ADDR_W-1:0] granted_addrs [$];

    always #2 clk = ~clk;

    // -------------------------------------------------------------------------
    // predictor: applies one request to the header image, returns the response
    // -------------------------------------------------------------------------
    function automatic heap_outcome_t predict_heap_op(input req_t kind,
                                                      input logic [SIZE_W-1:0] size,
                                                      input logic [ADDR_W-1:0] addr);
        heap_outcome_t res;
        logic [HDR_W-1:0] h;
        int need;
        int off;
        int sz;
        int hdr;
        bit broken;

        res.status = ST_NOSPACE;
        res.addr   = '0;
        off        = 0;
        broken     = 1'b0;
        if (kind == REQ_ALLOC)
        begin
            // round up to even, plus the 2-byte header
            need = ((int'(size) + 1) & ~1) + 2;
            if (live_now < int'(COUNT_MAX))
            begin
                while (off < ARENA_END)
                begin
                    h  = hdr_words[off / 2];
                    sz = int'(h & 16'hFFFE);
                    // a zero-size header ends the chain
                    if (sz == 0)
                        break;
                    if (!h[0] && sz >= need)
                    begin
                        if (sz <= need + 2)
                        begin
                            // taken whole, the next header is left alone
                            hdr_words[off / 2] = HDR_W'(sz | 1);
                        end
                        else
                        begin
                            // split, the remainder becomes a free block
                            hdr_words[off / 2]          = HDR_W'(need | 1);
                            hdr_words[(off + need) / 2] = HDR_W'(sz - need);
                        end
                        live_now++;
                        res.status = ST_OK;
                        res.addr   = ADDR_W'(off + 2);
                        break;
                    end
                    // free but too small, or in use: keep walking
                    off += sz;
                end
            end
        end
        else if (live_now == 0)
            res.status = ST_NONE;
        else if (addr[0] || addr < 2 || int'(addr) - 2 >= ARENA_END)
            res.status = ST_BADADDR;
        else
        begin
            hdr = int'(addr) - 2;
            while (off < hdr)
            begin
                sz = int'(hdr_words[off / 2] & 16'hFFFE);
                if (sz == 0)
                begin
                    broken = 1'b1;
                    break;
                end
                off += sz;
            end
            if (broken || off != hdr)
                res.status = ST_BADADDR;
            else if (!hdr_words[hdr / 2][0])
                res.status = ST_ISFREE;
            else
            begin
                hdr_words[hdr / 2][0] = 1'b0;
                live_now--;
                res.status = ST_OK;
            end
        end
        res.live = CNT_W'(live_now);
        return res;
    endfunction

    // -------------------------------------------------------------------------
    // request side: drives one word at the falling edge, holds it until taken
    // -------------------------------------------------------------------------
    task automatic send_word(input req_t kind, input int size, input int addr);
        heap_outcome_t exp_word;

        // random gap before the word, valid low meanwhile
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid      <= 1'b1;
        req.req_type   <= kind;
        req.alloc_size <= SIZE_W'(size);
        req.free_addr  <= ADDR_W'(addr);
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end

        // word taken at this edge: update the image and queue the response
        exp_word = predict_heap_op(kind, SIZE_W'(size), ADDR_W'(addr));
        outcomes_q.push_back(exp_word);
        if (exp_word.status == ST_OK && kind == REQ_ALLOC)
        begin
            live_addrs.push_back(exp_word.addr);
            granted_addrs.push_back(exp_word.addr);
        end
        else if (exp_word.status == ST_OK)
        begin
            for (int i = 0; i < live_addrs.size(); i++)
            begin
                if (live_addrs[i] == ADDR_W'(addr))
                begin
                    live_addrs.delete(i);
                    break;
                end
            end
        end
        @(negedge clk);
    endtask

    // holds off the request side until every expected response has come back
    task automatic wait_all_results();
        req.valid <= 1'b0;
        @(negedge clk);
        while (outcomes_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // -------------------------------------------------------------------------
    // response side: random backpressure, checks each word taken
    // -------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
            rsp.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        heap_outcome_t want;

        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (outcomes_q.size() == 0)
            begin
                $display("%0t: unexpected word: status %0d addr %0d live %0d",
                         $time, rsp.status, rsp.payload_addr, rsp.live_blocks);
                mismatches++;
            end
            else
            begin
                want = outcomes_q.pop_front();
                if (rsp.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp.status);
                    mismatches++;
                end
                if (rsp.payload_addr !== want.addr)
                begin
                    $display("%0t: payload_addr expected %0d actual %0d",
                             $time, want.addr, rsp.payload_addr);
                    mismatches++;
                end
                if (rsp.live_blocks !== want.live)
                begin
                    $display("%0t: live_blocks expected %0d actual %0d",
                             $time, want.live, rsp.live_blocks);
                    mismatches++;
                end
            end
        end
    end

    // -------------------------------------------------------------------------
    // directed tests; the layout notes give header offset : block size
    // -------------------------------------------------------------------------

    // nothing allocated yet, so any free is refused before the address checks
    task automatic test_free_when_empty();
        send_word(REQ_FREE, 0, 2);
    endtask

    // zero-size, odd and even payloads; each splits the tail block
    task automatic test_alloc_shapes();
        send_word(REQ_ALLOC, 0, 0);         // 0:2 header only, payload at 2
        send_word(REQ_ALLOC, 1, 0);         // 2:4, payload at 4
        send_word(REQ_ALLOC, 7, ADDR_TOP);  // 6:10, payload at 8
        send_word(REQ_ALLOC, 4, 0);         // 16:6, payload at 18, tail 22:32746
    endtask

    // odd, below two, inside a block, and inside the tail block at the arena end
    task automatic test_bad_frees();
        send_word(REQ_FREE, SIZE_TOP, 9);
        send_word(REQ_FREE, 0, 0);
        send_word(REQ_FREE, 0, 10);
        send_word(REQ_FREE, 0, 32766);
    endtask

    task automatic test_double_free();
        send_word(REQ_FREE, 0, 8);          // 6:10 now free
        send_word(REQ_FREE, 0, 8);          // already free
    endtask

    // first fit skips a free block that is too small, takes whole within two
    // bytes of slack, and an exact fit must not touch the following header
    task automatic test_first_fit_reuse();
        send_word(REQ_ALLOC, 12, 0);        // 6:10 too small, splits tail: 22:14
        send_word(REQ_ALLOC, 6, 0);         // 6:10 taken whole for need of 8
        send_word(REQ_FREE, 0, 18);
        send_word(REQ_ALLOC, 4, 0);         // 16:6 exact fit, 22 header stays
    endtask

    // oversize request, fill the arena exactly, then recover the tail
    task automatic test_arena_full();
        send_word(REQ_ALLOC, SIZE_TOP, 0);  // no space
        send_word(REQ_ALLOC, 32730, 0);     // 36:32732 exact fit of the tail
        send_word(REQ_ALLOC, 0, 0);         // every block in use
        send_word(REQ_FREE, 0, 38);
        send_word(REQ_ALLOC, 32728, 0);     // tail taken whole with slack
        send_word(REQ_FREE, 0, 38);
        send_word(REQ_FREE, 0, 24);         // walks the chain up to the 22 header and frees that block
    endtask

    // -------------------------------------------------------------------------
    // random traffic: mostly frees of live blocks and modest allocations,
    // with repeat frees and junk addresses mixed in
    // -------------------------------------------------------------------------
    task automatic test_random_traffic();
        int pick;
        int size;

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // a stretch with no gaps on either side
            quiet = (n >= 300 && n < 450);
            // let the pipeline empty out now and then
            if (n % 250 == 249)
                wait_all_results();

            pick = $urandom_range(0, 99);
            // keep the live set from growing without bound
            if (live_addrs.size() > 60 && pick < 25)
                pick += 45;

            if (pick < 45)
            begin
                size = $urandom_range(0, 99);
                if (size < 70)
                    size = $urandom_range(0, 64);
                else if (size < 95)
                    size = $urandom_range(65, 1500);
                else
                    size = $urandom_range(0, SIZE_TOP);
                send_word(REQ_ALLOC, size, $urandom_range(0, ADDR_TOP));
            end
            else if (pick < 85 && live_addrs.size() != 0)
                send_word(REQ_FREE, $urandom_range(0, SIZE_TOP),
                          live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
            else if (pick < 93 && granted_addrs.size() != 0)
                send_word(REQ_FREE, $urandom_range(0, SIZE_TOP),
                          granted_addrs[$urandom_range(0, granted_addrs.size() - 1)]);
            else
                send_word(REQ_FREE, $urandom_range(0, SIZE_TOP), $urandom_range(0, ADDR_TOP));
        end
        quiet = 1'b0;
    endtask

    // -------------------------------------------------------------------------
    // main sequence
    // -------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        quiet          = 1'b0;
        mismatches     = 0;
        req.valid      = 1'b0;
        req.req_type   = REQ_ALLOC;
        req.alloc_size = '0;
        req.free_addr  = '0;
        rsp.ready      = 1'b0;

        // after reset the whole arena is one free block at offset zero
        foreach (hdr_words[i])
            hdr_words[i] = '0;
        hdr_words[0] = HDR_W'(ARENA_END);
        live_now     = 0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_free_when_empty();
        test_alloc_shapes();
        test_bad_frees();
        test_double_free();
        test_first_fit_reuse();
        test_arena_full();
        wait_all_results();
        test_random_traffic();

        // drain, then leave room for any stray word
        wait_all_results();
        repeat (64) @(negedge clk);
        if (mismatches == 0)
            $display("first_fit_heap_allocator verification clean");
        else
            $display("first_fit_heap_allocator verification failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #100_000_000;
        $display("first_fit_heap_allocator verification failed");
        $finish;
    end

endmodule
